// File: sv/cra_pkg.sv
`default_nettype none
package cra_pkg;

  localparam int MaxRegions = 64;
  localparam int AddrBits   = 20;
  localparam int OwnerBits  = 16;
  localparam int IdxW       = $clog2(MaxRegions);
  localparam int CntW       = $clog2(MaxRegions + 1);

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_HELD    = 3'd2;
  localparam logic [2:0] ST_NOFIT   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  localparam logic [AddrBits-1:0] TotalReset = AddrBits'(1024);

  typedef struct packed {
    logic [AddrBits-1:0]  start;
    logic [AddrBits-1:0]  size;
    logic                 free;
    logic [OwnerBits-1:0] owner;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ROT,
    CMD_INS,
    CMD_DEL,
    CMD_WR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [IdxW-1:0] idx;
    entry_t          wa;
    entry_t          wb;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: sv/contiguous_region_allocator.sv
`default_nettype none
// channel   direction  handshake               word
// in        input      in_valid_i / in_ready_o   op, owner_id, req_size, strategy
// out       output     out_valid_o / out_ready_i status, start_addr
// cfg       input      cfg_we_i                  cfg_wdata_i (memory size)
//
// request and release, after the accept: a rotation of the 64-cell chain, then a decide
// state, up to two deletes of merged entries and the output load state.
// compact, after the accept: a delete sweep that takes the free entries out of the table,
// then a rotation that rewrites start addresses and appends any space left as a free region.
// after reset and after each cfg write the init state loads the single free region.
// a new word is taken while a finished result still waits in the output register.
module contiguous_region_allocator
  import cra_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [OwnerBits-1:0] owner_id_i,
  input  wire logic [AddrBits-1:0]  req_size_i,
  input  wire logic [1:0]           strategy_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [AddrBits-1:0]       start_addr_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrBits-1:0]  cfg_wdata_i
);

  cell_cmd_t             cmd;
  logic [IdxW-1:0]       probe;
  entry_t                ent [MaxRegions];
  logic [MaxRegions-1:0] hits;

  cra_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .owner_id_i   (owner_id_i),
    .req_size_i   (req_size_i),
    .strategy_i   (strategy_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .start_addr_o (start_addr_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .head_i       (ent[0]),
    .probe_hit_i  (|hits),
    .cmd_o        (cmd),
    .probe_o      (probe)
  );

  for (genvar i = 0; i < MaxRegions; i++) begin : g_cell
    entry_t lft, rgt;
    if (i == 0) begin : g_first
      assign lft = cmd.wa;
    end else begin : g_mid_l
      assign lft = ent[i-1];
    end
    if (i == MaxRegions - 1) begin : g_last
      assign rgt = (cmd.kind == CMD_ROT) ? cmd.wa : ent[i];
    end else begin : g_mid_r
      assign rgt = ent[i+1];
    end
    cra_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (IdxW'(i)),
      .cmd_i    (cmd),
      .probe_i  (probe),
      .left_i   (lft),
      .right_i  (rgt),
      .entry_o  (ent[i]),
      .hit_o    (hits[i])
    );
  end

endmodule
`default_nettype wire

// File: sv/cra_cell.sv
`default_nettype none
module cra_cell
  import cra_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic [IdxW-1:0] my_idx_i,
  input  wire cell_cmd_t       cmd_i,
  input  wire logic [IdxW-1:0] probe_i,
  input  wire entry_t          left_i,
  input  wire entry_t          right_i,
  output entry_t               entry_o,
  output logic                 hit_o
);

  entry_t entry_q, entry_d;
  logic [IdxW:0] my_ext, idx_ext, idx_nxt;

  assign my_ext  = {1'b0, my_idx_i};
  assign idx_ext = {1'b0, cmd_i.idx};
  assign idx_nxt = idx_ext + 1'b1;

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.kind)
      CMD_ROT: entry_d = right_i;
      CMD_INS: begin
        if (my_ext > idx_nxt) begin
          entry_d = left_i;
        end else if (my_ext == idx_nxt) begin
          entry_d = cmd_i.wb;
        end else if (my_ext == idx_ext) begin
          entry_d = cmd_i.wa;
        end
      end
      CMD_DEL: begin
        if (my_ext >= idx_ext) begin
          entry_d = right_i;
        end
      end
      CMD_WR: begin
        if (my_ext == idx_ext) begin
          entry_d = cmd_i.wa;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = entry_q.free && (my_idx_i == probe_i);

endmodule
`default_nettype wire

// File: sv/cra_ctrl.sv
`default_nettype none
module cra_ctrl
  import cra_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           op_i,
  input  wire logic [OwnerBits-1:0] owner_id_i,
  input  wire logic [AddrBits-1:0]  req_size_i,
  input  wire logic [1:0]           strategy_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic [AddrBits-1:0]       start_addr_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrBits-1:0]  cfg_wdata_i,
  input  wire entry_t               head_i,
  input  wire logic                 probe_hit_i,
  output cell_cmd_t                 cmd_o,
  output logic [IdxW-1:0]           probe_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_DEL    = 4'd4;
  localparam logic [3:0] S_CDEL   = 4'd5;
  localparam logic [3:0] S_CFIX   = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxRegions - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(MaxRegions);

  logic [3:0]           state_q, state_d;
  logic [1:0]           op_q, op_d, strat_q, strat_d;
  logic [OwnerBits-1:0] owner_q, owner_d;
  logic [AddrBits-1:0]  size_q, size_d, total_q, total_d;
  logic [CntW-1:0]      count_q, count_d, ptr_q, ptr_d;
  logic [IdxW-1:0]      t_q, t_d, r_q, r_d, pidx_q, pidx_d, del_idx_q, del_idx_d;
  logic                 found_q, found_d, pick_q, pick_d, nxt_ok_q, nxt_ok_d;
  logic                 hole_q, hole_d;
  logic [1:0]           ndel_q, ndel_d;
  entry_t               prev_q, prev_d, e_prev_q, e_prev_d, e_r_q, e_r_d;
  entry_t               e_next_q, e_next_d;
  logic [AddrBits-1:0]  psize_q, psize_d, pstart_q, pstart_d;
  logic [AddrBits:0]    pos_q, pos_d;
  logic [2:0]           status_q, status_d, ostat_q, ostat_d;
  logic [AddrBits-1:0]  addr_q, addr_d, oaddr_q, oaddr_d;
  logic                 ovalid_q, ovalid_d;

  logic          live, take, pfree, nfree;
  logic [CntW:0] t_ext;
  entry_t        w_a, w_b, fed;

  always_comb begin
    state_d = state_q;   op_d = op_q;         strat_d = strat_q;
    owner_d = owner_q;   size_d = size_q;     total_d = total_q;
    count_d = count_q;   ptr_d = ptr_q;       t_d = t_q;
    r_d = r_q;           pidx_d = pidx_q;     del_idx_d = del_idx_q;
    found_d = found_q;   pick_d = pick_q;     nxt_ok_d = nxt_ok_q;
    hole_d = hole_q;     ndel_d = ndel_q;     prev_d = prev_q;
    e_prev_d = e_prev_q; e_r_d = e_r_q;       e_next_d = e_next_q;
    psize_d = psize_q;   pstart_d = pstart_q; pos_d = pos_q;
    status_d = status_q; addr_d = addr_q;
    ostat_d = ostat_q;   oaddr_d = oaddr_q;   ovalid_d = ovalid_q;

    cmd_o    = '{kind: CMD_NOP, idx: '0, wa: '0, wb: '0};
    probe_o  = ptr_q[IdxW-1:0];
    live     = ({1'b0, t_q} < count_q);
    t_ext    = {2'b0, t_q} + 1'b1;
    take     = 1'b0;
    pfree    = (r_q != '0) && e_prev_q.free;
    nfree    = nxt_ok_q && e_next_q.free;
    w_a      = '0;
    w_b      = '0;
    fed      = head_i;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = op_i;
          owner_d  = owner_id_i;
          size_d   = req_size_i;
          strat_d  = strategy_i;
          t_d      = '0;
          ptr_d    = '0;
          found_d  = 1'b0;
          pick_d   = 1'b0;
          nxt_ok_d = 1'b0;
          hole_d   = 1'b0;
          pos_d    = '0;
          status_d = ST_OK;
          addr_d   = '0;
          unique case (op_i)
            OP_REQUEST, OP_RELEASE: state_d = S_SCAN;
            OP_COMPACT:             state_d = S_CDEL;
            default:                state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        cmd_o.kind = CMD_WR;
        cmd_o.wa   = '{start: '0, size: total_q, free: 1'b1, owner: '0};
        state_d    = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.kind = CMD_ROT;
        cmd_o.wa   = head_i;
        prev_d     = head_i;
        if (live && !head_i.free && head_i.owner == owner_q && !found_q) begin
          found_d  = 1'b1;
          r_d      = t_q;
          e_r_d    = head_i;
          e_prev_d = prev_q;
        end
        if (found_q && {1'b0, t_q} == {1'b0, r_q} + 1'b1) begin
          e_next_d = head_i;
          nxt_ok_d = live;
        end
        if (live && head_i.free && head_i.size >= size_q) begin
          unique case (strat_q)
            FIT_FIRST: take = !pick_q;
            FIT_BEST:  take = !pick_q || head_i.size < psize_q;
            FIT_WORST: take = !pick_q || head_i.size > psize_q;
            default:   take = 1'b0;
          endcase
        end
        if (take) begin
          pick_d   = 1'b1;
          pidx_d   = t_q;
          psize_d  = head_i.size;
          pstart_d = head_i.start;
        end
        t_d = t_q + 1'b1;
        if (t_q == LastIdx) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (op_q == OP_REQUEST) begin
          w_a = '{start: pstart_q, size: size_q, free: 1'b0, owner: owner_q};
          w_b = '{start: pstart_q + size_q, size: psize_q - size_q, free: 1'b1,
                  owner: '0};
          priority if (size_q == '0) begin
            status_d = ST_ZERO;
          end else if (found_q) begin
            status_d = ST_HELD;
          end else if (!pick_q) begin
            status_d = ST_NOFIT;
          end else if (psize_q == size_q) begin
            cmd_o    = '{kind: CMD_WR, idx: pidx_q, wa: w_a, wb: w_b};
            addr_d   = pstart_q;
          end else if (count_q >= MaxCnt) begin
            status_d = ST_FULL;
          end else begin
            cmd_o    = '{kind: CMD_INS, idx: pidx_q, wa: w_a, wb: w_b};
            count_d  = count_q + 1'b1;
            addr_d   = pstart_q;
          end
        end else if (!found_q) begin
          status_d = ST_UNKNOWN;
        end else begin
          addr_d = e_r_q.start;
          priority if (pfree && nfree) begin
            w_a       = '{start: e_prev_q.start,
                          size: e_prev_q.size + e_r_q.size + e_next_q.size,
                          free: 1'b1, owner: '0};
            cmd_o     = '{kind: CMD_WR, idx: r_q - 1'b1, wa: w_a, wb: w_b};
            del_idx_d = r_q;
            ndel_d    = 2'd2;
            count_d   = count_q - 2'd2;
            state_d   = S_DEL;
          end else if (pfree) begin
            w_a       = '{start: e_prev_q.start, size: e_prev_q.size + e_r_q.size,
                          free: 1'b1, owner: '0};
            cmd_o     = '{kind: CMD_WR, idx: r_q - 1'b1, wa: w_a, wb: w_b};
            del_idx_d = r_q;
            ndel_d    = 2'd1;
            count_d   = count_q - 1'b1;
            state_d   = S_DEL;
          end else if (nfree) begin
            w_a       = '{start: e_r_q.start, size: e_r_q.size + e_next_q.size,
                          free: 1'b1, owner: '0};
            cmd_o     = '{kind: CMD_WR, idx: r_q, wa: w_a, wb: w_b};
            del_idx_d = r_q + 1'b1;
            ndel_d    = 2'd1;
            count_d   = count_q - 1'b1;
            state_d   = S_DEL;
          end else begin
            w_a   = '{start: e_r_q.start, size: e_r_q.size, free: 1'b1, owner: '0};
            cmd_o = '{kind: CMD_WR, idx: r_q, wa: w_a, wb: w_b};
          end
        end
      end
      S_DEL: begin
        cmd_o.kind = CMD_DEL;
        cmd_o.idx  = del_idx_q;
        ndel_d     = ndel_q - 1'b1;
        if (ndel_q == 2'd1) begin
          state_d = S_DONE;
        end
      end
      S_CDEL: begin
        if (ptr_q >= count_q) begin
          t_d     = '0;
          state_d = S_CFIX;
        end else if (probe_hit_i) begin
          cmd_o.kind = CMD_DEL;
          cmd_o.idx  = ptr_q[IdxW-1:0];
          count_d    = count_q - 1'b1;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      S_CFIX: begin
        if (live) begin
          fed.start = pos_q[AddrBits-1:0];
          pos_d     = pos_q + {1'b0, head_i.size};
        end else if ({1'b0, t_q} == count_q && pos_q < {1'b0, total_q}
                     && count_q < MaxCnt) begin
          fed    = '{start: pos_q[AddrBits-1:0],
                     size: total_q - pos_q[AddrBits-1:0], free: 1'b1, owner: '0};
          hole_d = 1'b1;
        end
        cmd_o.kind = CMD_ROT;
        cmd_o.wa   = fed;
        t_d        = t_q + 1'b1;
        if (t_q == LastIdx) begin
          count_d = count_q + CntW'(hole_d);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ostat_d  = status_q;
          oaddr_d  = addr_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
      count_d = CntW'(1);
      state_d = S_INIT;
    end
    if (t_ext > {1'b0, MaxCnt}) begin
      t_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      total_q  <= TotalReset;
      count_q  <= CntW'(1);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;      strat_q   <= strat_d;   owner_q  <= owner_d;
    size_q    <= size_d;    ptr_q     <= ptr_d;     t_q      <= t_d;
    r_q       <= r_d;       pidx_q    <= pidx_d;    del_idx_q <= del_idx_d;
    found_q   <= found_d;   pick_q    <= pick_d;    nxt_ok_q <= nxt_ok_d;
    hole_q    <= hole_d;    ndel_q    <= ndel_d;    prev_q   <= prev_d;
    e_prev_q  <= e_prev_d;  e_r_q     <= e_r_d;     e_next_q <= e_next_d;
    psize_q   <= psize_d;   pstart_q  <= pstart_d;  pos_q    <= pos_d;
    status_q  <= status_d;  addr_q    <= addr_d;
    ostat_q   <= ostat_d;   oaddr_q   <= oaddr_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = ovalid_q;
  assign status_o     = ostat_q;
  assign start_addr_o = oaddr_q;

endmodule
`default_nettype wire
